// ----- rtl/core/deadline_timer_table_assert.svh -----
// Assertion macros for the deadline timer table.
`ifndef DEADLINE_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTT_ASSERT(lbl, prop, msg)
`define DTT_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/dtt_pkg.sv -----
// Shared constants and types for the deadline timer table.
package dtt_pkg;

  localparam int SLOTS  = 32;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W = 5;
  localparam int MIN_W  = 10;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic [MIN_W-1:0]  MIN_DELAY_RESET = 10'd10;
  localparam logic [DATA_W-1:0] NO_DEADLINE     = 32'hFFFF_FFFF;

  localparam logic [0:0] REG_IDX_MIN_DELAY = 1'b0;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FIRED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REJECTED  = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] deadline;
  } kd_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } args_t;

endpackage

// ----- rtl/core/deadline_timer_table.sv -----
// Deadline timer table: keyed one-shot deadlines held in two synchronous memories.
// The done strobe ends every accepted item: a plain tick needs no table walk, a stop or a full
// table needs one, an expiring tick one scan and a start two; busy drops the cycle after done.
// Each table walk reads one slot per cycle through the key/deadline read port.
// Synchronous reset empties every slot, disarms the countdown and sets the minimum delay to 10.
`include "deadline_timer_table_assert.svh"
module deadline_timer_table import dtt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [DATA_W-1:0]   key,
  input  logic [DATA_W-1:0]   delay,
  input  logic [DATA_W-1:0]   arg_a,
  input  logic [DATA_W-1:0]   arg_b,
  input  logic [DATA_W-1:0]   arg_c,
  output logic                done,
  output logic [2:0]          status,
  output logic [DATA_W-1:0]   fired_key,
  output logic [DATA_W-1:0]   out_a,
  output logic [DATA_W-1:0]   out_b,
  output logic [DATA_W-1:0]   out_c,
  output logic [SLOT_W-1:0]   slot,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_FIRE   = 3'd4;
  localparam logic [2:0] S_SCAN   = 3'd5;
  localparam logic [2:0] S_ARM    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        func_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] dl_q;
  args_t             args_q;
  logic [SLOTS-1:0]  valid;
  logic [DATA_W-1:0] now_ms;
  logic              armed;
  logic [IDX_W-1:0]  armed_slot;
  logic [DATA_W-1:0] countdown;
  logic [MIN_W-1:0]  min_delay;
  logic              found_match;
  logic [IDX_W-1:0]  match_idx;
  logic              found_empty;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              found;
  logic [DATA_W-1:0] best;
  logic [IDX_W-1:0]  pick;
  logic [2:0]        res_status;
  logic [DATA_W-1:0] res_key;
  args_t             res_args;
  logic [SLOT_W-1:0] res_slot;

  kd_t               kd_mem [SLOTS];
  args_t             args_mem [SLOTS];
  kd_t               kd_rdata;
  args_t             args_rdata;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;

  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  eval_idx;
  logic              ent_valid;
  logic              cfg_we;
  logic [DATA_W-1:0] min_ext;
  logic [DATA_W-1:0] remain;

  assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_IDX_MIN_DELAY);
  assign pready  = 1'b1;
  assign min_ext = {{(DATA_W-MIN_W){1'b0}}, min_delay};
  assign prdata  = (paddr[2] == REG_IDX_MIN_DELAY) ? min_ext : '0;

  assign cnt_m1    = cnt - CNT_W'(1);
  assign eval_idx  = cnt_m1[IDX_W-1:0];
  assign ent_valid = valid[eval_idx];
  assign remain    = best - now_ms;

  assign rd_addr = ((state == S_FIND) || (state == S_SCAN)) ? cnt[IDX_W-1:0] : armed_slot;
  assign mem_we  = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      kd_mem[wr_idx] <= '{key: key_q, deadline: dl_q};
    end
    kd_rdata <= kd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      args_mem[wr_idx] <= args_q;
    end
    args_rdata <= args_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      valid      <= '0;
      now_ms     <= '0;
      armed      <= 1'b0;
      armed_slot <= '0;
      countdown  <= '0;
      min_delay  <= MIN_DELAY_RESET;
    end else begin
      if (cfg_we) begin
        min_delay <= pwdata[MIN_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            func_q      <= func;
            key_q       <= key;
            dl_q        <= now_ms + delay;
            args_q      <= '{a: arg_a, b: arg_b, c: arg_c};
            res_key     <= '0;
            res_args    <= '0;
            res_slot    <= '0;
            cnt         <= '0;
            found_match <= 1'b0;
            match_idx   <= '0;
            found_empty <= 1'b0;
            free_idx    <= '0;
            found       <= 1'b0;
            best        <= NO_DEADLINE;
            pick        <= '0;
            case (func)
              FUNC_START, FUNC_STOP: begin
                if (key == '0) begin
                  res_status <= ST_REJECTED;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_FIND;
                end
              end
              FUNC_TICK: begin
                res_status <= ST_OK;
                now_ms     <= now_ms + DATA_W'(1);
                if (armed && (countdown <= DATA_W'(1))) begin
                  countdown <= '0;
                  armed     <= 1'b0;
                  state     <= S_FIRE;
                end else begin
                  if (armed) begin
                    countdown <= countdown - DATA_W'(1);
                  end
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_FIND: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt != '0) begin
            if (ent_valid && (kd_rdata.key == key_q) && !found_match) begin
              found_match <= 1'b1;
              match_idx   <= eval_idx;
            end
            if (!ent_valid && !found_empty) begin
              found_empty <= 1'b1;
              free_idx    <= eval_idx;
            end
          end
          if (cnt == CNT_W'(SLOTS)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (func_q == FUNC_START) begin
            if (found_match) begin
              wr_idx <= match_idx;
              state  <= S_WRITE;
            end else if (found_empty) begin
              wr_idx <= free_idx;
              state  <= S_WRITE;
            end else begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end
          end else begin
            if (found_match) begin
              valid[match_idx] <= 1'b0;
              res_slot         <= SLOT_W'(match_idx);
            end else begin
              res_status <= ST_NOT_FOUND;
            end
            state <= S_DONE;
          end
        end
        S_WRITE: begin
          valid[wr_idx] <= 1'b1;
          res_slot      <= SLOT_W'(wr_idx);
          cnt           <= '0;
          state         <= S_SCAN;
        end
        S_FIRE: begin
          if (valid[armed_slot]) begin
            res_status        <= ST_FIRED;
            res_key           <= kd_rdata.key;
            res_args          <= args_rdata;
            res_slot          <= SLOT_W'(armed_slot);
            valid[armed_slot] <= 1'b0;
          end
          cnt   <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if ((cnt != '0) && ent_valid && (kd_rdata.deadline < best)) begin
            best  <= kd_rdata.deadline;
            pick  <= eval_idx;
            found <= 1'b1;
          end
          if (cnt == CNT_W'(SLOTS)) begin
            state <= S_ARM;
          end
        end
        S_ARM: begin
          if (found) begin
            if ((now_ms > best) || (remain < min_ext)) begin
              countdown <= min_ext;
            end else begin
              countdown <= remain;
            end
            armed      <= 1'b1;
            armed_slot <= pick;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign status    = res_status;
  assign fired_key = res_key;
  assign out_a     = res_args.a;
  assign out_b     = res_args.b;
  assign out_c     = res_args.c;
  assign slot      = res_slot;

  `DTT_ASSERT(a_done_single, done |=> !done, "Result strobe lasted more than one cycle.")
  `DTT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "Accepted item did not raise busy.")
  `DTT_ASSERT(a_fired_key, (done && (status == ST_FIRED)) |-> (fired_key != '0), "Fired an empty key.")
  `DTT_ASSERT(a_arm_floor, ((state == S_ARM) && found) |=> (armed && (countdown >= $past(min_ext))), "Countdown armed below the floor.")
  `DTT_ASSERT(a_valid_idle, !busy |=> $stable(valid), "Table contents changed while idle.")
  `DTT_ASSERT_RST(a_reset_state, rst |=> (!busy && !armed), "Reset left the block busy or armed.")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the deadline timer table: directed and random items, APB setup.
module tb;
  import dtt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] MIN_DELAY_ADDR = PADDR_W'({REG_IDX_MIN_DELAY, 2'b00});
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int KEY_POOL = 40;

  typedef struct {
    logic [1:0]        func;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] delay;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } timer_cmd_t;

  typedef struct {
    logic [2:0]        status;
    logic [DATA_W-1:0] fired_key;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [SLOT_W-1:0] slot;
  } timer_result_t;

  class timer_scoreboard;
    logic [DATA_W-1:0] key_tab[SLOTS];
    logic [DATA_W-1:0] deadline_tab[SLOTS];
    args_t             args_tab[SLOTS];
    logic [DATA_W-1:0] now_ms;
    bit                armed;
    logic [SLOT_W-1:0] armed_slot;
    logic [DATA_W-1:0] countdown;
    logic [MIN_W-1:0]  min_delay;
    timer_result_t     expected_q[$];
    int                errors;

    function new();
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      now_ms = '0;
      armed = 1'b0;
      armed_slot = '0;
      countdown = '0;
      min_delay = MIN_DELAY_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_slot(int i);
      key_tab[i] = '0;
      deadline_tab[i] = '0;
      args_tab[i] = '0;
    endfunction

    // Arms the countdown for the earliest deadline; an empty scan leaves it untouched.
    function void rearm();
      logic [DATA_W-1:0] best;
      int pick;
      bit found;
      best = NO_DEADLINE;
      pick = 0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (key_tab[i] != '0 && deadline_tab[i] < best) begin
          best = deadline_tab[i];
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) return;
      if (now_ms > best || (best - now_ms) < DATA_W'(min_delay)) begin
        countdown = DATA_W'(min_delay);
      end else begin
        countdown = best - now_ms;
      end
      armed = 1'b1;
      armed_slot = SLOT_W'(pick);
    endfunction

    function void note_item(timer_cmd_t cmd);
      timer_result_t r;
      int idx;
      int free_idx;
      bit hit;
      bit have_empty;
      int s;
      r = '{default: '0};
      hit = 1'b0;
      have_empty = 1'b0;
      idx = 0;
      free_idx = 0;
      case (cmd.func)
        FUNC_START: begin
          if (cmd.key == '0) begin
            r.status = ST_REJECTED;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit) begin
                if (key_tab[i] == cmd.key) begin
                  idx = i;
                  hit = 1'b1;
                end else if (!have_empty && key_tab[i] == '0) begin
                  free_idx = i;
                  have_empty = 1'b1;
                end
              end
            end
            if (!hit && !have_empty) begin
              r.status = ST_FULL;
            end else begin
              if (!hit) idx = free_idx;
              key_tab[idx] = cmd.key;
              args_tab[idx] = '{a: cmd.a, b: cmd.b, c: cmd.c};
              deadline_tab[idx] = now_ms + cmd.delay;
              r.status = ST_OK;
              r.slot = SLOT_W'(idx);
              rearm();
            end
          end
        end
        FUNC_STOP: begin
          if (cmd.key == '0) begin
            r.status = ST_REJECTED;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit && key_tab[i] == cmd.key) begin
                clear_slot(i);
                r.slot = SLOT_W'(i);
                hit = 1'b1;
              end
            end
            r.status = hit ? ST_OK : ST_NOT_FOUND;
          end
        end
        FUNC_TICK: begin
          now_ms = now_ms + 1;
          if (armed) begin
            if (countdown > 1) begin
              countdown = countdown - 1;
            end else begin
              s = int'(armed_slot);
              countdown = '0;
              armed = 1'b0;
              if (key_tab[s] != '0) begin
                r.status = ST_FIRED;
                r.fired_key = key_tab[s];
                r.a = args_tab[s].a;
                r.b = args_tab[s].b;
                r.c = args_tab[s].c;
                r.slot = SLOT_W'(s);
                clear_slot(s);
              end
              rearm();
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (errors < 100) $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(timer_result_t got);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", DATA_W'(got.status), '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
      if (got.fired_key !== want.fired_key)
        report_mismatch("fired_key", got.fired_key, want.fired_key);
      if (got.a !== want.a) report_mismatch("out_a", got.a, want.a);
      if (got.b !== want.b) report_mismatch("out_b", got.b, want.b);
      if (got.c !== want.c) report_mismatch("out_c", got.c, want.c);
      if (got.slot !== want.slot)
        report_mismatch("slot", DATA_W'(got.slot), DATA_W'(want.slot));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          func = '0;
  logic [DATA_W-1:0]   key = '0;
  logic [DATA_W-1:0]   delay = '0;
  logic [DATA_W-1:0]   arg_a = '0;
  logic [DATA_W-1:0]   arg_b = '0;
  logic [DATA_W-1:0]   arg_c = '0;
  logic                done;
  logic [2:0]          status;
  logic [DATA_W-1:0]   fired_key;
  logic [DATA_W-1:0]   out_a;
  logic [DATA_W-1:0]   out_b;
  logic [DATA_W-1:0]   out_c;
  logic [SLOT_W-1:0]   slot;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  timer_scoreboard sb = new();
  int unsigned cycles = 0;

  deadline_timer_table dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result('{status: status, fired_key: fired_key, a: out_a, b: out_b,
                        c: out_c, slot: slot});
    end
  end

  function automatic timer_cmd_t make_cmd(logic [1:0] f, logic [DATA_W-1:0] k,
                                          logic [DATA_W-1:0] d, logic [DATA_W-1:0] a,
                                          logic [DATA_W-1:0] b, logic [DATA_W-1:0] c);
    timer_cmd_t cmd;
    cmd = '{func: f, key: k, delay: d, a: a, b: b, c: c};
    return cmd;
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return DATA_W'($urandom_range(1, KEY_POOL));
    if (r < 85) return '0;
    if (r < 90) return '1;
    return $urandom;
  endfunction

  function automatic logic [DATA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return DATA_W'($urandom_range(0, 2 * int'(sb.min_delay) + 20));
    if (r < 75) return DATA_W'($urandom_range(0, 5));
    if (r < 85) return $urandom;
    if (r < 90) return '1;
    return NO_DEADLINE - DATA_W'($urandom_range(0, 100));
  endfunction

  function automatic timer_cmd_t mixed_cmd();
    int r;
    logic [1:0] f;
    r = $urandom_range(0, 99);
    if (r < 35) f = FUNC_START;
    else if (r < 50) f = FUNC_STOP;
    else if (r < 95) f = FUNC_TICK;
    else f = FUNC_UNUSED;
    return make_cmd(f, pick_key(), pick_delay(), $urandom, $urandom, $urandom);
  endfunction

  // Start stays high after acceptance; the caller lowers it only before a real gap.
  task automatic send_item(timer_cmd_t cmd);
    func <= cmd.func;
    key <= cmd.key;
    delay <= cmd.delay;
    arg_a <= cmd.a;
    arg_b <= cmd.b;
    arg_c <= cmd.c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd);
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MIN_DELAY_ADDR) sb.min_delay = data[MIN_W-1:0];
  endtask

  task automatic set_min_delay(int value);
    write_reg(MIN_DELAY_ADDR, {DATA_W'($urandom) >> MIN_W << MIN_W} | DATA_W'(value));
  endtask

  function automatic int pick_idle_pct();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return 67;
    return 19;
  endfunction

  task automatic run_phase(int n_items);
    int sent;
    int kind;
    int len;
    int pct;
    int offset;
    timer_cmd_t cmd;
    sent = 0;
    while (sent < n_items) begin
      pct = pick_idle_pct();
      kind = $urandom_range(0, 9);
      if (kind < 6) len = $urandom_range(10, 40);
      else if (kind < 8) len = $urandom_range(1, int'(sb.min_delay) + 40);
      else if (kind == 8) len = SLOTS + 2;
      else len = 20;
      offset = $urandom_range(0, KEY_POOL - 1);
      for (int i = 0; i < len; i++) begin
        if (kind < 6) begin
          cmd = mixed_cmd();
        end else if (kind < 8) begin
          cmd = make_cmd(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (kind == 8) begin
          // Distinct keys, more of them than there are slots, so the table fills up.
          cmd = make_cmd(FUNC_START, DATA_W'((offset + i) % KEY_POOL + 1), pick_delay(),
                         $urandom, $urandom, $urandom);
        end else begin
          cmd = make_cmd(FUNC_STOP, DATA_W'($urandom_range(1, KEY_POOL)), $urandom,
                         $urandom, $urandom, $urandom);
        end
        idle_gap(pct);
        send_item(cmd);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_min_delay(0);
    write_reg(UNMAPPED_ADDR, $urandom);

    send_item(make_cmd(FUNC_START, '0, 5, 1, 2, 3));
    send_item(make_cmd(FUNC_STOP, '0, 0, 0, 0, 0));
    send_item(make_cmd(FUNC_STOP, 7, 0, 0, 0, 0));
    send_item(make_cmd(FUNC_UNUSED, '1, '1, '1, '1, '1));
    send_item(make_cmd(FUNC_START, '1, 0, '1, '1, '1));
    send_item(make_cmd(FUNC_START, 1, '1, 0, 0, 0));
    send_item(make_cmd(FUNC_START, 2, 3, $urandom, $urandom, $urandom));
    // The armed entry is stopped, so the next expiry fires nothing.
    send_item(make_cmd(FUNC_STOP, '1, 0, 0, 0, 0));
    repeat (4) send_item(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0));
    send_item(make_cmd(FUNC_START, 9, 2, $urandom, $urandom, $urandom));
    send_item(make_cmd(FUNC_START, 9, 1, $urandom, $urandom, $urandom));
    send_item(make_cmd(FUNC_TICK, '1, '1, '1, '1, '1));
    send_item(make_cmd(FUNC_STOP, 1, 0, 0, 0, 0));
    send_item(make_cmd(FUNC_TICK, 0, 0, 0, 0, 0));

    set_min_delay(10);
    run_phase(350);
    set_min_delay(1);
    run_phase(250);
    set_min_delay(1023);
    run_phase(1000);
    set_min_delay($urandom_range(2, 1022));
    run_phase(200);
    set_min_delay(5);
    run_phase(150);

    wait_idle();
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dtt_pkg.sv
rtl/core/deadline_timer_table.sv
tb/tb.sv
